@@ rtl/vsat_pkg.sv @@
// Shared types and constants of the video scroll and address timing unit.
package vsat_pkg;

  // Request kinds
  localparam logic [1:0] ReqTick  = 2'd0;
  localparam logic [1:0] ReqWrite = 2'd1;
  localparam logic [1:0] ReqRead  = 2'd2;

  // Register numbers
  localparam logic [2:0] RegCtrl    = 3'd0;
  localparam logic [2:0] RegStatus  = 3'd2;
  localparam logic [2:0] RegOamAddr = 3'd3;
  localparam logic [2:0] RegOamData = 3'd4;
  localparam logic [2:0] RegScroll  = 3'd5;
  localparam logic [2:0] RegAddr    = 3'd6;
  localparam logic [2:0] RegData    = 3'd7;

  // Raster timing
  localparam logic [8:0] DotLast      = 9'd340;
  localparam logic [8:0] LineLast     = 9'd261;
  localparam logic [8:0] LineVisible  = 9'd240;
  localparam logic [8:0] LineVblank   = 9'd241;
  localparam logic [8:0] DotVertInc   = 9'd256;
  localparam logic [8:0] DotHorizCopy = 9'd257;
  localparam logic [8:0] DotOamLast   = 9'd320;
  localparam logic [8:0] DotVertFirst = 9'd280;
  localparam logic [8:0] DotVertLast  = 9'd304;
  localparam logic [8:0] DotPrefetch0 = 9'd328;
  localparam logic [8:0] DotPrefetch1 = 9'd336;
  localparam logic [8:0] DotFlagEvent = 9'd1;

  // VRAM address field masks
  localparam logic [14:0] VertMask  = 15'h7BE0;
  localparam logic [14:0] HorizMask = 15'h041F;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] reg_index;
    logic [7:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [14:0] vram_addr;
    logic [2:0]  fine_x_out;
    logic        nmi_raised;
    logic        vblank_flag;
    logic [7:0]  oam_addr_out;
    logic [8:0]  line_out;
    logic [8:0]  dot_out;
  } out_item_t;

endpackage

@@ rtl/vsat_in_stage.sv @@
// Input register stage: captures one request per transfer.
module vsat_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vsat_pkg::in_item_t in_data_i,
  input  logic               advance_i,
  output logic               valid_o,
  output vsat_pkg::in_item_t item_o
);

  logic               valid_q, valid_d;
  vsat_pkg::in_item_t item_q;

  // Free when empty or when the held item moves on this cycle
  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ rtl/vsat_regs.sv @@
// Scroll, address and raster state with the per-request update logic.
module vsat_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  vsat_pkg::in_item_t  item_i,
  output vsat_pkg::out_item_t result_o
);

  logic [14:0] cur_q, cur_d;
  logic [14:0] tmp_q, tmp_d;
  logic [2:0]  fine_x_q, fine_x_d;
  logic        toggle_q, toggle_d;
  logic [7:0]  ctrl_q, ctrl_d;
  logic [7:0]  oam_q, oam_d;
  logic        vblank_q, vblank_d;
  logic [8:0]  dot_q, dot_d;
  logic [8:0]  line_q, line_d;
  logic [7:0]  rd;
  logic        nmi;

  // Next row: fine Y first, then coarse Y with nametable flip at row 29
  function automatic logic [14:0] vert_step(input logic [14:0] a);
    logic [14:0] r;
    r = a;
    if (a[14:12] != 3'd7) begin
      r[14:12] = a[14:12] + 3'd1;
    end else begin
      r[14:12] = 3'd0;
      if (a[9:5] == 5'd29) begin
        r[9:5] = 5'd0;
        r[11]  = ~a[11];
      end else if (a[9:5] == 5'd31) begin
        r[9:5] = 5'd0;
      end else begin
        r[9:5] = a[9:5] + 5'd1;
      end
    end
    return r;
  endfunction

  // Next tile column, flipping the horizontal nametable on wrap
  function automatic logic [14:0] horiz_step(input logic [14:0] a);
    logic [14:0] r;
    r = a;
    r[4:0] = a[4:0] + 5'd1;
    if (a[4:0] == 5'd31) begin
      r[10] = ~a[10];
    end
    return r;
  endfunction

  // Data port increment: across (1) or down (32)
  function automatic logic [14:0] data_step(input logic [14:0] a, input logic down);
    return a + (down ? 15'd32 : 15'd1);
  endfunction

  always_comb begin
    cur_d    = cur_q;
    tmp_d    = tmp_q;
    fine_x_d = fine_x_q;
    toggle_d = toggle_q;
    ctrl_d   = ctrl_q;
    oam_d    = oam_q;
    vblank_d = vblank_q;
    dot_d    = dot_q;
    line_d   = line_q;
    rd       = 8'd0;
    nmi      = 1'b0;

    case (item_i.req_type)
      vsat_pkg::ReqTick: begin
        if (line_q < vsat_pkg::LineVisible) begin
          if (line_q == 9'd0) begin
            if (dot_q == vsat_pkg::DotFlagEvent) begin
              vblank_d = 1'b0;
            end
            if (dot_q >= vsat_pkg::DotVertFirst && dot_q <= vsat_pkg::DotVertLast) begin
              cur_d = (cur_d & ~vsat_pkg::VertMask) | (tmp_q & vsat_pkg::VertMask);
            end
          end
          if (dot_q == vsat_pkg::DotVertInc) begin
            cur_d = vert_step(cur_d);
          end
          if (dot_q[2:0] == 3'd0 &&
              ((dot_q >= 9'd8 && dot_q <= vsat_pkg::DotVertInc) ||
               dot_q == vsat_pkg::DotPrefetch0 || dot_q == vsat_pkg::DotPrefetch1)) begin
            cur_d = horiz_step(cur_d);
          end
          if (dot_q == vsat_pkg::DotHorizCopy) begin
            cur_d = (cur_d & ~vsat_pkg::HorizMask) | (tmp_q & vsat_pkg::HorizMask);
          end
          if (dot_q >= vsat_pkg::DotHorizCopy && dot_q <= vsat_pkg::DotOamLast) begin
            oam_d = 8'd0;
          end
        end else if (line_q == vsat_pkg::LineVblank && dot_q == vsat_pkg::DotFlagEvent) begin
          vblank_d = 1'b1;
          nmi      = ctrl_q[7];
        end
        // Raster counters
        if (dot_q >= vsat_pkg::DotLast) begin
          dot_d  = 9'd0;
          line_d = (line_q >= vsat_pkg::LineLast) ? 9'd0 : line_q + 9'd1;
        end else begin
          dot_d = dot_q + 9'd1;
        end
      end
      vsat_pkg::ReqWrite: begin
        case (item_i.reg_index)
          vsat_pkg::RegCtrl: begin
            tmp_d[11:10] = item_i.write_data[1:0];
            toggle_d     = 1'b0;
            ctrl_d       = item_i.write_data;
          end
          vsat_pkg::RegOamAddr: oam_d = item_i.write_data;
          vsat_pkg::RegOamData: oam_d = oam_q + 8'd1;
          vsat_pkg::RegScroll: begin
            if (!toggle_q) begin
              tmp_d[4:0] = item_i.write_data[7:3];
              fine_x_d   = item_i.write_data[2:0];
            end else begin
              tmp_d[14:12] = item_i.write_data[2:0];
              tmp_d[9:5]   = item_i.write_data[7:3];
            end
            toggle_d = ~toggle_q;
          end
          vsat_pkg::RegAddr: begin
            if (!toggle_q) begin
              tmp_d[14]   = 1'b0;
              tmp_d[13:8] = item_i.write_data[5:0];
            end else begin
              tmp_d[7:0] = item_i.write_data;
              cur_d      = tmp_d;
            end
            toggle_d = ~toggle_q;
          end
          vsat_pkg::RegData: cur_d = data_step(cur_q, ctrl_q[2]);
          default: ;
        endcase
      end
      vsat_pkg::ReqRead: begin
        if (item_i.reg_index == vsat_pkg::RegStatus) begin
          rd       = {vblank_q, 7'd0};
          vblank_d = 1'b0;
          toggle_d = 1'b0;
        end else if (item_i.reg_index == vsat_pkg::RegData) begin
          cur_d = data_step(cur_q, ctrl_q[2]);
        end
      end
      default: ;
    endcase
  end

  // State commits only when the request is consumed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q    <= '0;
      tmp_q    <= '0;
      fine_x_q <= '0;
      toggle_q <= 1'b0;
      ctrl_q   <= '0;
      oam_q    <= '0;
      vblank_q <= 1'b0;
      dot_q    <= '0;
      line_q   <= '0;
    end else if (fire_i) begin
      cur_q    <= cur_d;
      tmp_q    <= tmp_d;
      fine_x_q <= fine_x_d;
      toggle_q <= toggle_d;
      ctrl_q   <= ctrl_d;
      oam_q    <= oam_d;
      vblank_q <= vblank_d;
      dot_q    <= dot_d;
      line_q   <= line_d;
    end
  end

  assign result_o = '{
    read_data:    rd,
    vram_addr:    cur_d,
    fine_x_out:   fine_x_d,
    nmi_raised:   nmi,
    vblank_flag:  vblank_d,
    oam_addr_out: oam_d,
    line_out:     line_d,
    dot_out:      dot_d
  };

endmodule

@@ rtl/video_scroll_address_timing.sv @@
// Top level of the video scroll and address timing unit.
//
// Input channel (in_valid_i / in_ready_o / in_data_i) carries one request per
// transfer: a dot tick, a register write or a register read. The output
// channel (out_valid_o / out_ready_i / out_data_o) returns exactly one result
// per request, in order: read byte, current VRAM address, fine X, NMI pulse,
// vblank flag, OAM address and the raster position after the request.
// A request passes the input register, then the result register, before its
// result appears on out_data_o. Throughput: one request per cycle while the
// receiver does not stall, set by the combinational update of the scroll/raster
// state between the input and result registers.
// Reset clears all state; raster starts at dot 0 of the pre-render line.
// When the receiver stalls, the result is held, the input register keeps one
// more request, and in_ready_o drops until the result is taken.
module video_scroll_address_timing (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  vsat_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output vsat_pkg::out_item_t  out_data_o
);

  logic                stage_valid;
  vsat_pkg::in_item_t  stage_item;
  logic                advance;
  vsat_pkg::out_item_t result;
  logic                out_valid_q, out_valid_d;
  vsat_pkg::out_item_t out_q;

  // Held request moves when the result register is free or draining
  assign advance = stage_valid && (!out_valid_q || out_ready_i);

  vsat_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  vsat_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .item_i   (stage_item),
    .result_o (result)
  );

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/vsat_checker.sv @@
// Port-level assertions for the video scroll and address timing unit.
module vsat_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input vsat_pkg::out_item_t out_data_o
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // NMI only on the tick that opens vblank
  a_nmi_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.nmi_raised |->
      out_data_o.vblank_flag && out_data_o.line_out == 9'd241 &&
      out_data_o.dot_out == 9'd2)
    else $error("nmi outside vblank start");

  // Raster position in range
  a_raster: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.dot_out <= 9'd340 && out_data_o.line_out <= 9'd261)
    else $error("raster counter out of range");

  // Status byte carries only the vblank bit
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.read_data[6:0] == 7'd0)
    else $error("read data low bits set");

endmodule

bind video_scroll_address_timing vsat_checker u_vsat_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
